[rtl/core/ampb_pkg.sv]
`default_nettype none

package ampb_pkg;

  // Default frame size and beep length in frames
  localparam int unsigned FRAME_CHANNELS_DEF = 2;
  localparam int unsigned BEEP_LENGTH_DEF    = 4096;

  // Sawtooth step per countdown unit
  localparam logic [15:0] TONE_STEP  = 16'd1486;
  // ceil(2^18 / 6): exact divide by 6 for magnitudes up to 32768
  localparam logic [15:0] TONE_RECIP = 16'd43691;
  localparam int unsigned TONE_SHIFT = 18;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_c;
    logic               enable_a;
    logic               enable_b;
    logic               enable_c;
    logic        [15:0] gain_a;
    logic        [15:0] gain_b;
    logic        [15:0] gain_c;
    logic               end_of_buffer;
    logic               beep_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic        [15:0] buffer_peak;
    logic               peak_valid;
  } out_item_t;

  // Beep status handed from the countdown to the output stage
  typedef struct packed {
    logic        active;
    logic [15:0] raw;
  } beep_info_t;

endpackage

`default_nettype wire

[rtl/core/ampb_gain.sv]
`default_nettype none

module ampb_gain
  import ampb_pkg::*;
(
  input  wire logic               clk,
  input  wire in_item_t           item,
  input  wire logic               advance,
  output logic signed [32:0]      prod_a,
  output logic signed [32:0]      prod_b,
  output logic signed [32:0]      prod_c,
  output logic                    buffer_end
);

  logic signed [16:0] gain_a_s;
  logic signed [16:0] gain_b_s;
  logic signed [16:0] gain_c_s;

  // Gains are unsigned; a zero top bit keeps them positive
  assign gain_a_s = {1'b0, item.gain_a};
  assign gain_b_s = {1'b0, item.gain_b};
  assign gain_c_s = {1'b0, item.gain_c};

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_a     <= item.enable_a ? 33'(item.sample_a) * 33'(gain_a_s) : '0;
      prod_b     <= item.enable_b ? 33'(item.sample_b) * 33'(gain_b_s) : '0;
      prod_c     <= item.enable_c ? 33'(item.sample_c) * 33'(gain_c_s) : '0;
      buffer_end <= item.end_of_buffer;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ampb_beep.sv]
`default_nettype none

module ampb_beep
  import ampb_pkg::*;
#(
  parameter int unsigned FRAME_CHANNELS = FRAME_CHANNELS_DEF,
  parameter int unsigned BEEP_LENGTH    = BEEP_LENGTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire logic  beep_start,
  output beep_info_t info
);

  localparam logic [15:0] BEEP_LOAD  = 16'(BEEP_LENGTH);
  localparam logic [3:0]  FRAME_SIZE = 4'(FRAME_CHANNELS);

  logic [15:0] count;
  logic [15:0] count_next;
  logic [15:0] count_eff;
  logic [2:0]  position;
  logic [2:0]  position_next;
  logic        frame_end;

  always_comb begin
    count_eff     = beep_start ? BEEP_LOAD : count;
    frame_end     = ({1'b0, position} + 4'd1) >= FRAME_SIZE;
    position_next = frame_end ? 3'd0 : position + 3'd1;
    count_next    = (frame_end && (count_eff != '0)) ? count_eff - 16'd1 : count_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      position <= '0;
    end else if (advance) begin
      count    <= count_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      info.active <= (count_eff != '0);
      info.raw    <= 16'(count_eff * TONE_STEP);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= BEEP_LOAD)
    else $error("beep countdown above its load value");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, position} < FRAME_SIZE))
    else $error("frame position outside the frame");

endmodule

`default_nettype wire

[rtl/core/ampb_mix.sv]
`default_nettype none

module ampb_mix
  import ampb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic signed [32:0] prod_a,
  input  wire logic signed [32:0] prod_b,
  input  wire logic signed [32:0] prod_c,
  input  wire logic               buffer_end,
  input  wire beep_info_t         info,
  output out_item_t               result
);

  logic signed [34:0] sum;
  logic signed [34:0] sum_rnd;
  logic signed [19:0] rounded;
  logic signed [15:0] mixed;
  logic signed [16:0] mixed_x;
  logic        [15:0] mag;
  logic        [15:0] peak;
  logic        [15:0] peak_cur;
  logic signed [16:0] raw_x;
  logic        [15:0] tone_mag;
  logic        [31:0] tone_prod;
  logic        [12:0] tone_q;
  logic signed [15:0] tone;

  always_comb begin
    // Q5.30 sum, round half up to Q1.15, then clip
    sum     = 35'(prod_a) + 35'(prod_b) + 35'(prod_c);
    sum_rnd = sum + 35'sd16384;
    rounded = sum_rnd[34:15];
    if (rounded > 20'sd32767) begin
      mixed = 16'sh7FFF;
    end else if (rounded < -20'sd32768) begin
      mixed = 16'sh8000;
    end else begin
      mixed = rounded[15:0];
    end
    mixed_x  = 17'(mixed);
    mag      = mixed[15] ? 16'(-mixed_x) : 16'(mixed_x);
    peak_cur = (mag > peak) ? mag : peak;

    // Sawtooth: signed raw word / 6, truncated toward zero
    raw_x     = 17'($signed(info.raw));
    tone_mag  = info.raw[15] ? 16'(-raw_x) : info.raw;
    tone_prod = tone_mag * TONE_RECIP;
    tone_q    = tone_prod[TONE_SHIFT+12:TONE_SHIFT];
    tone      = info.raw[15] ? -16'(tone_q) : 16'(tone_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (advance) begin
      peak <= buffer_end ? '0 : peak_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.mixed_sample <= info.active ? tone : mixed;
      result.buffer_peak  <= buffer_end ? peak_cur : '0;
      result.peak_valid   <= buffer_end;
    end
  end

endmodule

`default_nettype wire

[rtl/core/audio_mixer_peak_beep_unit.sv]
`default_nettype none
// Pipeline: three register stages, input register first and output register last.
// Throughput: one transaction per cycle; every stage moves on each cycle unless the
//   output is stalled, and a stalled output backs up stage by stage to the input.
// Reset (rst, synchronous, active high): empties the pipe, clears the buffer
//   peak, the beep countdown and the frame position.

module audio_mixer_peak_beep_unit
  import ampb_pkg::*;
#(
  parameter int unsigned FRAME_CHANNELS = FRAME_CHANNELS_DEF,
  parameter int unsigned BEEP_LENGTH    = BEEP_LENGTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result
);

  // Stage 1: input register. Stage 2: products and beep state.
  // Stage 3: sum, clip, peak, tone select (output register).
  in_item_t item_q;
  logic     v1;
  logic     v2;
  logic     v3;
  logic     adv1;
  logic     adv2;
  logic     adv3;
  logic     en2;
  logic     en3;

  logic signed [32:0] prod_a;
  logic signed [32:0] prod_b;
  logic signed [32:0] prod_c;
  logic               buffer_end;
  beep_info_t         info;

  // A stage may load when it is empty or its contents move on
  always_comb begin
    adv3 = !v3 || !result_stall;
    adv2 = !v2 || adv3;
    adv1 = !v1 || adv2;
    en2  = v1 && adv2;
    en3  = v2 && adv3;
  end

  assign item_stall   = !adv1;
  assign result_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= item_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && adv1) begin
      item_q <= item;
    end
  end

  // Gain products for the three sources
  ampb_gain u_gain (
    .clk        (clk),
    .item       (item_q),
    .advance    (en2),
    .prod_a     (prod_a),
    .prod_b     (prod_b),
    .prod_c     (prod_c),
    .buffer_end (buffer_end)
  );

  // Beep countdown and frame position; advance once per transaction
  ampb_beep #(
    .FRAME_CHANNELS (FRAME_CHANNELS),
    .BEEP_LENGTH    (BEEP_LENGTH)
  ) u_beep (
    .clk        (clk),
    .rst        (rst),
    .advance    (en2),
    .beep_start (item_q.beep_start),
    .info       (info)
  );

  // Mix, clip, peak meter and tone override
  ampb_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .advance    (en3),
    .prod_a     (prod_a),
    .prod_b     (prod_b),
    .prod_c     (prod_c),
    .buffer_end (buffer_end),
    .info       (info),
    .result     (result)
  );

  // Input only backs up when every stage holds a transaction and the output waits
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (v1 && v2 && v3 && result_stall))
    else $error("input stalled with room in the pipe");

  // Peak only reported on a buffer end
  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.peak_valid) |-> (result.buffer_peak == '0))
    else $error("peak reported without buffer end");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.buffer_peak <= 16'd32768))
    else $error("peak above full scale");

  // A result held under stall keeps its stage full next cycle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && result_stall && v2) |=> (v2 && v3))
    else $error("stage lost under stall");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

// Testbench for audio_mixer_peak_beep_unit.
// A scoreboard predicts every output sample at the moment its input transaction
// is accepted. The checker compares each accepted output transaction against
// the oldest prediction.

module tb;
  import ampb_pkg::*;

  // DUT configuration (package defaults)
  localparam int unsigned FRAME_CH = FRAME_CHANNELS_DEF;
  localparam int unsigned BEEP_LEN = BEEP_LENGTH_DEF;

  // Pipe depth from the DUT header, used for the settle waits
  localparam int LATENCY = 3;

  // Sawtooth generator constants
  localparam int SAW_STEP = 1486;
  localparam int SAW_DIV  = 6;

  // Global watchdog (ns): far beyond the slowest legal run
  localparam longint WATCHDOG_NS = 64'd20_000_000;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  audio_mixer_peak_beep_unit #(
    .FRAME_CHANNELS(FRAME_CH),
    .BEEP_LENGTH   (BEEP_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // ---------------------------------------------------------------------
  // Scoreboard state: shadow copies of the mixer's registers
  // ---------------------------------------------------------------------
  logic [15:0] pk_running;   // running buffer peak
  logic [15:0] beep_left;    // frames of beep remaining
  int          frame_pos;    // sample position inside the frame

  out_item_t   mix_results_q[$];   // predicted output samples, oldest first
  out_item_t   want;

  int errors;
  int n_sent, n_checked, n_peaks, n_tone, n_clip, n_in_stall;

  // Sender pacing
  int burst_left;
  bit pace_on;

  // Receiver control: hold_left forces a long stall, rx_busy enables the
  // random stall pattern
  int hold_left;
  bit rx_busy;

  // ---------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("watchdog expired at %0t, %0d results still pending", $time,
             mix_results_q.size());
    $display("[audio_mixer_peak_beep_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: one input transaction in, one output sample out. Updates the
  // shadow state exactly as the mixer does.
  // ---------------------------------------------------------------------
  function automatic out_item_t mix_and_meter(input in_item_t it);
    longint             acc;
    longint             rounded;
    logic        [15:0] mag;
    logic signed [15:0] saw_raw;
    int                 saw;
    out_item_t          r;
    acc = 0;
    if (it.enable_a) acc += longint'($signed(it.sample_a)) * longint'(it.gain_a);
    if (it.enable_b) acc += longint'($signed(it.sample_b)) * longint'(it.gain_b);
    if (it.enable_c) acc += longint'($signed(it.sample_c)) * longint'(it.gain_c);

    // Q5.30 -> Q1.15, round half up (arithmetic shift is a floor)
    rounded = (acc + 64'sd16384) >>> 15;
    if (rounded > 32767) begin
      rounded = 32767;
      n_clip++;
    end else if (rounded < -32768) begin
      rounded = -32768;
      n_clip++;
    end

    // Magnitude of the clamped mix; -32768 gives 32768
    mag = 16'((rounded < 0) ? -rounded : rounded);
    if (mag > pk_running) pk_running = mag;

    r.buffer_peak = '0;
    r.peak_valid  = 1'b0;
    if (it.end_of_buffer) begin
      r.buffer_peak = pk_running;
      r.peak_valid  = 1'b1;
      pk_running    = '0;
    end

    // Reload takes effect on this very sample
    if (it.beep_start) beep_left = BEEP_LEN[15:0];

    r.mixed_sample = rounded[15:0];
    if (beep_left != 0) begin
      saw_raw        = 16'(32'(beep_left) * SAW_STEP);
      saw            = int'(saw_raw) / SAW_DIV;   // truncates toward zero
      r.mixed_sample = saw[15:0];
      n_tone++;
    end

    // Frame counter runs always; the countdown falls once per frame, floor 0
    if (frame_pos + 1 >= int'(FRAME_CH)) begin
      frame_pos = 0;
      if (beep_left != 0) beep_left--;
    end else begin
      frame_pos++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic signed [15:0] sa, sb, sc,
                                       input logic [2:0] en,
                                       input logic [15:0] ga, gb, gc,
                                       input logic eob, beep);
    in_item_t it;
    it.sample_a      = sa;
    it.sample_b      = sb;
    it.sample_c      = sc;
    it.enable_a      = en[2];
    it.enable_b      = en[1];
    it.enable_c      = en[0];
    it.gain_a        = ga;
    it.gain_b        = gb;
    it.gain_c        = gc;
    it.end_of_buffer = eob;
    it.beep_start    = beep;
    return it;
  endfunction

  // Samples lean on full scale and near-zero values
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Gains lean on zero, half, unity and the top of the 16-bit range
  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2:    return 16'd32768;
      3:       return 16'd65535;
      4:       return 16'd16384;
      5:       return 16'($urandom_range(0, 32768));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item(input logic beep);
    return mk_item(rand_sample(), rand_sample(), rand_sample(), 3'($urandom),
                   rand_gain(), rand_gain(), rand_gain(),
                   ($urandom_range(0, 5) == 0), beep);
  endfunction

  // Offer one transaction and hold it until accepted; predict at acceptance.
  // Valid is left high so back-to-back transactions need no extra edge.
  task automatic send_item(input in_item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) begin
      n_in_stall++;
      @(posedge clk);
    end
    mix_results_q.push_back(mix_and_meter(it));
    n_sent++;
    if (pace_on) sender_pace();
  endtask

  // Bursts of random length; between bursts a random idle gap
  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering, let every predicted sample come out, then let the pipe settle
  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (mix_results_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall pattern, plus a counted long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : rx_stall_gen
    int  run_left;
    bit  stalled;
    run_left = 0;
    stalled  = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          stalled  = rx_busy && ($urandom_range(0, 2) == 0);
          run_left = stalled ? $urandom_range(1, 6)
                   : (($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 15));
        end
        run_left--;
        result_stall <= stalled;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (mix_results_q.size() == 0) begin
        $display("%0t: unexpected output transaction %p", $time, result);
        errors++;
      end else begin
        want = mix_results_q.pop_front();
        n_checked++;
        if (want.peak_valid) n_peaks++;
        if (result.mixed_sample !== want.mixed_sample) begin
          $display("%0t: mixed_sample expected %0d actual %0d", $time,
                   want.mixed_sample, result.mixed_sample);
          errors++;
        end
        if (result.buffer_peak !== want.buffer_peak) begin
          $display("%0t: buffer_peak expected %0d actual %0d", $time,
                   want.buffer_peak, result.buffer_peak);
          errors++;
        end
        if (result.peak_valid !== want.peak_valid) begin
          $display("%0t: peak_valid expected %0b actual %0b", $time,
                   want.peak_valid, result.peak_valid);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Full scale, clipping, rounding ties and peak meter corner cases
  task automatic test_directed_mix();
    // all sources off: values must not leak into the mix
    send_item(mk_item(16'sh7fff, 16'sh8000, 16'sh7fff, 3'b000,
                      16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0));
    // unity gain passes full scale unchanged
    send_item(mk_item(16'sh7fff, 16'sd0, 16'sd0, 3'b100,
                      16'd32768, 16'd0, 16'd0, 1'b0, 1'b0));
    // most negative sample: magnitude 32768 reaches the peak
    send_item(mk_item(16'sh8000, 16'sd0, 16'sd0, 3'b100,
                      16'd32768, 16'd0, 16'd0, 1'b1, 1'b0));
    // three sources at max gain clip high, then low
    send_item(mk_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111,
                      16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0));
    send_item(mk_item(16'sh8000, 16'sh8000, 16'sh8000, 3'b111,
                      16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0));
    // half-LSB ties round toward plus infinity
    send_item(mk_item(16'sd1, 16'sd0, 16'sd0, 3'b100,
                      16'd16384, 16'd0, 16'd0, 1'b0, 1'b0));
    send_item(mk_item(-16'sd1, 16'sd0, 16'sd0, 3'b100,
                      16'd16384, 16'd0, 16'd0, 1'b0, 1'b0));
    // just under and just over a tie
    send_item(mk_item(16'sd1, 16'sd0, 16'sd0, 3'b100,
                      16'd16383, 16'd0, 16'd0, 1'b0, 1'b0));
    send_item(mk_item(-16'sd1, 16'sd0, 16'sd0, 3'b100,
                      16'd16385, 16'd0, 16'd0, 1'b1, 1'b0));
    // single sources b and c, then a and c cancelling
    send_item(mk_item(16'sd0, -16'sd12345, 16'sd0, 3'b010,
                      16'd0, 16'd40000, 16'd0, 1'b0, 1'b0));
    send_item(mk_item(16'sd0, 16'sd0, 16'sd23456, 3'b001,
                      16'd0, 16'd0, 16'd20000, 1'b0, 1'b0));
    send_item(mk_item(16'sd1000, 16'sd0, -16'sd1000, 3'b101,
                      16'd32768, 16'd0, 16'd32768, 1'b1, 1'b0));
    // back-to-back buffer ends: one-sample buffer, then a silent one
    send_item(mk_item(16'sd300, 16'sd0, 16'sd0, 3'b100,
                      16'd32768, 16'd0, 16'd0, 1'b1, 1'b0));
    send_item(mk_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 3'b111,
                      16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    // above-unity gain on a sum that stays in range
    send_item(mk_item(16'sd100, 16'sd200, -16'sd50, 3'b111,
                      16'd65535, 16'd50000, 16'd33000, 1'b1, 1'b0));
  endtask

  // Random mixes with random buffer boundaries
  task automatic test_random_mix(input int count);
    repeat (count) send_item(rand_item(1'b0));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the pipe must fill and stall the input
  task automatic test_backpressure();
    bit saved;
    saved   = pace_on;
    pace_on = 1'b0;
    hold_left = 300;
    repeat (60) send_item(rand_item(1'b0));
    pace_on = saved;
  endtask

  // Sender stops until every prediction is retired, then resumes
  task automatic test_drain_pause();
    wait_for_results();
    repeat (30) send_item(rand_item(1'b0));
  endtask

  // Beep tone: start, let the sawtooth step down over a stretch of frames,
  // then restart mid-beep on an odd frame position together with a buffer end
  task automatic test_beep();
    in_item_t it;
    int       k;
    send_item(rand_item(1'b1));
    for (k = 0; k < 120; k++) send_item(rand_item(1'b0));
    while (frame_pos != 1) send_item(rand_item(1'b0));
    it = rand_item(1'b1);
    it.end_of_buffer = 1'b1;
    send_item(it);
    repeat (60) send_item(rand_item(1'b0));
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    errors     = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_peaks    = 0;
    n_tone     = 0;
    n_clip     = 0;
    n_in_stall = 0;
    burst_left = 0;
    pace_on    = 1'b0;
    hold_left  = 0;
    rx_busy    = 1'b0;
    pk_running = '0;
    beep_left  = '0;
    frame_pos  = 0;

    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    pace_on = 1'b1;
    rx_busy = 1'b1;
    test_directed_mix();
    test_random_mix(200);
    test_backpressure();
    test_drain_pause();
    test_beep();

    wait_for_results();
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d transactions: %0d checked, %0d buffer peaks, %0d clipped mixes",
             n_sent, n_checked, n_peaks, n_clip);
    $display("beep tone on %0d samples; input held off %0d cycles by backpressure",
             n_tone, n_in_stall);
    if (errors == 0) begin
      $display("[audio_mixer_peak_beep_unit] OK");
    end else begin
      $display("[audio_mixer_peak_beep_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ampb_pkg.sv
rtl/core/ampb_gain.sv
rtl/core/ampb_beep.sv
rtl/core/ampb_mix.sv
rtl/core/audio_mixer_peak_beep_unit.sv
dv/tb.sv
